### rtl/core/directional_focus_rect_compare_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the directional focus rectangle comparator
// Short forms for same-cycle and next-cycle implications on clk / rst_n.
// ----------------------------------------------------------------------------
`ifndef DIRECTIONAL_FOCUS_RECT_COMPARE_TOP_MACROS_SVH
`define DIRECTIONAL_FOCUS_RECT_COMPARE_TOP_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define DFRC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define DFRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/dfrc_pkg.sv
// ----------------------------------------------------------------------------
// dfrc_pkg
// Shared types and constants of the directional focus rectangle comparator.
// ----------------------------------------------------------------------------
`default_nettype none

package dfrc_pkg;

    localparam int DFRC_COORD_WIDTH = 16;
    localparam int DFRC_CFG_IDX_W   = 3;

    // Configuration register map
    typedef enum logic [DFRC_CFG_IDX_W-1:0] {
        REG_NODE_LEFT,
        REG_NODE_TOP,
        REG_NODE_RIGHT,
        REG_NODE_BOTTOM,
        REG_SEARCH_DIR
    } dfrc_reg_idx_t;

    typedef enum logic [1:0] {
        DIR_UP,
        DIR_DOWN,
        DIR_LEFT,
        DIR_RIGHT
    } dfrc_dir_t;

    // Per-rectangle geometric tests against the source rectangle
    typedef struct packed {
        logic cand;     // lies further along the search direction at both edges
        logic beam;     // overlaps the source on the cross axis
        logic to_dir;   // fully past the source's leading edge
    } dfrc_flags_t;

endpackage

`default_nettype wire

### rtl/core/dfrc_in_if.sv
// ----------------------------------------------------------------------------
// dfrc_in_if
// Input channel: candidate and current best rectangles, one pair per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface dfrc_in_if import dfrc_pkg::*; #(
    parameter int COORD_WIDTH = DFRC_COORD_WIDTH
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] item_left;
    logic signed [COORD_WIDTH-1:0] item_top;
    logic signed [COORD_WIDTH-1:0] item_right;
    logic signed [COORD_WIDTH-1:0] item_bottom;
    logic signed [COORD_WIDTH-1:0] best_left;
    logic signed [COORD_WIDTH-1:0] best_top;
    logic signed [COORD_WIDTH-1:0] best_right;
    logic signed [COORD_WIDTH-1:0] best_bottom;

    modport source (
        output valid, item_left, item_top, item_right, item_bottom,
        output best_left, best_top, best_right, best_bottom,
        input  ready
    );

    modport sink (
        input  valid, item_left, item_top, item_right, item_bottom,
        input  best_left, best_top, best_right, best_bottom,
        output ready
    );
endinterface

`default_nettype wire

### rtl/core/dfrc_out_if.sv
// ----------------------------------------------------------------------------
// dfrc_out_if
// Result channel: one decision bit per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface dfrc_out_if ();
    logic valid;
    logic ready;
    logic item_is_better;

    modport source (
        output valid, item_is_better,
        input  ready
    );

    modport sink (
        input  valid, item_is_better,
        output ready
    );
endinterface

`default_nettype wire

### rtl/core/dfrc_cfg_if.sv
// ----------------------------------------------------------------------------
// dfrc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface dfrc_cfg_if import dfrc_pkg::*; #(
    parameter int COORD_WIDTH = DFRC_COORD_WIDTH
) ();
    logic                      valid;
    logic                      ready;
    logic [DFRC_CFG_IDX_W-1:0] index;
    logic [COORD_WIDTH-1:0]    data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

### rtl/core/dfrc_cfg_regs.sv
// ----------------------------------------------------------------------------
// dfrc_cfg_regs
// Source rectangle and search direction registers behind the write channel.
// ----------------------------------------------------------------------------
`default_nettype none

module dfrc_cfg_regs import dfrc_pkg::*; #(
    parameter int COORD_WIDTH = DFRC_COORD_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    dfrc_cfg_if.sink                      cfg,
    output logic signed [COORD_WIDTH-1:0] node_left,
    output logic signed [COORD_WIDTH-1:0] node_top,
    output logic signed [COORD_WIDTH-1:0] node_right,
    output logic signed [COORD_WIDTH-1:0] node_bottom,
    output dfrc_dir_t                     search_direction
);

    logic signed [COORD_WIDTH-1:0] node_left_reg;
    logic signed [COORD_WIDTH-1:0] node_top_reg;
    logic signed [COORD_WIDTH-1:0] node_right_reg;
    logic signed [COORD_WIDTH-1:0] node_bottom_reg;
    dfrc_dir_t                     dir_reg;

    // Writes are always accepted
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_left_reg   <= '0;
            node_top_reg    <= '0;
            node_right_reg  <= '0;
            node_bottom_reg <= '0;
            dir_reg         <= DIR_UP;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_NODE_LEFT:   node_left_reg   <= cfg.data;
                REG_NODE_TOP:    node_top_reg    <= cfg.data;
                REG_NODE_RIGHT:  node_right_reg  <= cfg.data;
                REG_NODE_BOTTOM: node_bottom_reg <= cfg.data;
                REG_SEARCH_DIR:  dir_reg         <= dfrc_dir_t'(cfg.data[1:0]);
                default:         ;  // unmapped index, write dropped
            endcase
        end
    end

    assign node_left        = node_left_reg;
    assign node_top         = node_top_reg;
    assign node_right       = node_right_reg;
    assign node_bottom      = node_bottom_reg;
    assign search_direction = dir_reg;

endmodule

`default_nettype wire

### rtl/core/dfrc_rect_eval.sv
// ----------------------------------------------------------------------------
// dfrc_rect_eval
// Geometry of one rectangle against the source: tests, distances, weight.
// ----------------------------------------------------------------------------
`default_nettype none

module dfrc_rect_eval import dfrc_pkg::*; #(
    parameter int COORD_WIDTH = DFRC_COORD_WIDTH
) (
    input  logic signed [COORD_WIDTH-1:0] node_left,
    input  logic signed [COORD_WIDTH-1:0] node_top,
    input  logic signed [COORD_WIDTH-1:0] node_right,
    input  logic signed [COORD_WIDTH-1:0] node_bottom,
    input  logic signed [COORD_WIDTH-1:0] rect_left,
    input  logic signed [COORD_WIDTH-1:0] rect_top,
    input  logic signed [COORD_WIDTH-1:0] rect_right,
    input  logic signed [COORD_WIDTH-1:0] rect_bottom,
    input  logic                          horiz,
    input  logic                          neg,
    output dfrc_flags_t                   flags,
    output logic [COORD_WIDTH-1:0]        near_major,
    output logic [COORD_WIDTH-1:0]        far_major,
    output logic [2*COORD_WIDTH+6:0]      weight
);

    localparam int W = COORD_WIDTH;

    // Major / cross axis views, sign extended by one bit
    logic signed [W:0]   n_mlo, n_mhi, n_clo, n_chi;
    logic signed [W:0]   r_mlo, r_mhi, r_clo, r_chi;
    logic signed [W:0]   d_near, d_far;
    logic signed [W:0]   sum_n, sum_r;
    logic signed [W+1:0] d_minor;
    logic [W+1:0]        d_minor_u;
    logic [W+1:0]        minor_mag;
    logic [2*W-1:0]      near_sq;
    logic [2*W+3:0]      minor_sq;
    logic [2*W+6:0]      near_sq_x;

    always_comb
    begin
        if (horiz)
        begin
            n_mlo = {node_left[W-1],   node_left};
            n_mhi = {node_right[W-1],  node_right};
            n_clo = {node_top[W-1],    node_top};
            n_chi = {node_bottom[W-1], node_bottom};
            r_mlo = {rect_left[W-1],   rect_left};
            r_mhi = {rect_right[W-1],  rect_right};
            r_clo = {rect_top[W-1],    rect_top};
            r_chi = {rect_bottom[W-1], rect_bottom};
        end
        else
        begin
            n_mlo = {node_top[W-1],    node_top};
            n_mhi = {node_bottom[W-1], node_bottom};
            n_clo = {node_left[W-1],   node_left};
            n_chi = {node_right[W-1],  node_right};
            r_mlo = {rect_top[W-1],    rect_top};
            r_mhi = {rect_bottom[W-1], rect_bottom};
            r_clo = {rect_left[W-1],   rect_left};
            r_chi = {rect_right[W-1],  rect_right};
        end
    end

    always_comb
    begin
        if (neg)
        begin
            flags.cand   = (n_mlo > r_mlo) && (n_mhi > r_mhi);
            flags.to_dir = (n_mlo >= r_mhi);
            d_near       = n_mlo - r_mhi;
            d_far        = n_mlo - r_mlo;
        end
        else
        begin
            flags.cand   = (n_mlo < r_mlo) && (n_mhi < r_mhi);
            flags.to_dir = (n_mhi <= r_mlo);
            d_near       = r_mlo - n_mhi;
            d_far        = r_mhi - n_mhi;
        end
        flags.beam = (n_clo < r_chi) && (r_clo < n_chi);
    end

    // Near gap clamped at zero, far gap clamped at one
    assign near_major = (!d_near[W] && (d_near != '0)) ? d_near[W-1:0] : '0;
    assign far_major  = (!d_far[W] && (d_far[W:1] != '0)) ? d_far[W-1:0]
                                                          : {{(W-1){1'b0}}, 1'b1};

    // Doubled centers keep the half bit exact
    assign sum_n     = n_clo + n_chi;
    assign sum_r     = r_clo + r_chi;
    assign d_minor   = {sum_n[W], sum_n} - {sum_r[W], sum_r};
    assign d_minor_u = d_minor;
    assign minor_mag = d_minor_u[W+1] ? (~d_minor_u + 1'b1) : d_minor_u;

    assign near_sq   = near_major * near_major;
    assign minor_sq  = minor_mag * minor_mag;
    assign near_sq_x = {7'b0, near_sq};

    // 52 * major^2 + minor2^2, with 52 = 32 + 16 + 4
    assign weight = (near_sq_x << 5) + (near_sq_x << 4) + (near_sq_x << 2)
                  + {3'b0, minor_sq};

endmodule

`default_nettype wire

### rtl/core/dfrc_decide.sv
// ----------------------------------------------------------------------------
// dfrc_decide
// Priority rules that turn both rectangles' geometry into the final verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module dfrc_decide import dfrc_pkg::*; #(
    parameter int COORD_WIDTH = DFRC_COORD_WIDTH
) (
    input  dfrc_flags_t                flags_item,
    input  dfrc_flags_t                flags_best,
    input  logic [COORD_WIDTH-1:0]     near_item,
    input  logic [COORD_WIDTH-1:0]     far_item,
    input  logic [COORD_WIDTH-1:0]     near_best,
    input  logic [COORD_WIDTH-1:0]     far_best,
    input  logic [2*COORD_WIDTH+6:0]   weight_item,
    input  logic [2*COORD_WIDTH+6:0]   weight_best,
    input  logic                       horiz,
    output logic                       item_is_better
);

    logic item_beats_best;
    logic best_beats_item;

    // Outright win: winner in the beam, loser out of it, and the loser either
    // not fully past the source, farther than the winner's near gap, or the search horizontal
    assign item_beats_best = flags_item.beam && !flags_best.beam &&
                             (!flags_best.to_dir || horiz || (near_item < far_best));
    assign best_beats_item = flags_best.beam && !flags_item.beam &&
                             (!flags_item.to_dir || horiz || (near_best < far_item));

    always_comb
    begin
        if (!flags_item.cand)
            item_is_better = 1'b0;
        else if (!flags_best.cand)
            item_is_better = 1'b1;
        else if (item_beats_best)
            item_is_better = 1'b1;
        else if (best_beats_item)
            item_is_better = 1'b0;
        else
            item_is_better = (weight_item < weight_best);
    end

endmodule

`default_nettype wire

### rtl/core/directional_focus_rect_compare_top.sv
// ----------------------------------------------------------------------------
// directional_focus_rect_compare_top
// Streams candidate/best rectangle pairs and flags when the candidate wins.
// ----------------------------------------------------------------------------
// Usage:
//   cfg  - write channel for the source rectangle (indexes 0..3: left, top,
//          right, bottom) and the search direction (index 4: 0 up, 1 down,
//          2 left, 3 right). Always ready; write only while no item is in
//          flight. Unmapped indexes are dropped.
//   req  - one item = candidate rectangle plus current best rectangle.
//   rsp  - one item = item_is_better for the matching request, in order.
// Path: an accepted request lands in the input register; its result is
//   then registered in the result register and offered on rsp.
// Throughput: one item per cycle. The input register and the result
//   register form a two-deep pipeline, so req stays ready while a finished
//   result waits; req.ready only drops when both stages are full and rsp
//   is stalled. The path between the two registers holds four parallel
//   squarers (two COORD_WIDTH, two COORD_WIDTH+2 bits wide), adders and compares.
// Reset: clears both pipeline valid bits and all configuration registers
//   (source rectangle at zero, direction up). No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module directional_focus_rect_compare_top import dfrc_pkg::*; #(
    parameter int COORD_WIDTH = DFRC_COORD_WIDTH
) (
    input  logic        clk,
    input  logic        rst_n,
    dfrc_cfg_if.sink    cfg,
    dfrc_in_if.sink     req,
    dfrc_out_if.source  rsp
);

    localparam int W = COORD_WIDTH;

    // Configuration
    logic signed [W-1:0] node_left, node_top, node_right, node_bottom;
    dfrc_dir_t           search_direction;
    logic                horiz;
    logic                neg;

    // Input register stage
    logic                s1_valid_reg;
    logic signed [W-1:0] item_left_reg, item_top_reg, item_right_reg, item_bottom_reg;
    logic signed [W-1:0] best_left_reg, best_top_reg, best_right_reg, best_bottom_reg;

    // Evaluation results
    dfrc_flags_t         flags_item, flags_best;
    logic [W-1:0]        near_item, far_item, near_best, far_best;
    logic [2*W+6:0]      weight_item, weight_best;
    logic                better_next;

    // Result register stage
    logic                out_valid_reg;
    logic                better_reg;
    logic                out_advance;

    dfrc_cfg_regs #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_cfg (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .node_left        (node_left),
        .node_top         (node_top),
        .node_right       (node_right),
        .node_bottom      (node_bottom),
        .search_direction (search_direction)
    );

    // Horizontal search uses x as the major axis; up and left look negative
    assign horiz = (search_direction == DIR_LEFT) || (search_direction == DIR_RIGHT);
    assign neg   = (search_direction == DIR_UP)   || (search_direction == DIR_LEFT);

    // Pipeline handshake: result slot frees when empty or being taken
    assign out_advance = !out_valid_reg || rsp.ready;
    assign req.ready   = !s1_valid_reg || out_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (req.ready)
            s1_valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            item_left_reg   <= req.item_left;
            item_top_reg    <= req.item_top;
            item_right_reg  <= req.item_right;
            item_bottom_reg <= req.item_bottom;
            best_left_reg   <= req.best_left;
            best_top_reg    <= req.best_top;
            best_right_reg  <= req.best_right;
            best_bottom_reg <= req.best_bottom;
        end
    end

    dfrc_rect_eval #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_eval_item (
        .node_left   (node_left),
        .node_top    (node_top),
        .node_right  (node_right),
        .node_bottom (node_bottom),
        .rect_left   (item_left_reg),
        .rect_top    (item_top_reg),
        .rect_right  (item_right_reg),
        .rect_bottom (item_bottom_reg),
        .horiz       (horiz),
        .neg         (neg),
        .flags       (flags_item),
        .near_major  (near_item),
        .far_major   (far_item),
        .weight      (weight_item)
    );

    dfrc_rect_eval #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_eval_best (
        .node_left   (node_left),
        .node_top    (node_top),
        .node_right  (node_right),
        .node_bottom (node_bottom),
        .rect_left   (best_left_reg),
        .rect_top    (best_top_reg),
        .rect_right  (best_right_reg),
        .rect_bottom (best_bottom_reg),
        .horiz       (horiz),
        .neg         (neg),
        .flags       (flags_best),
        .near_major  (near_best),
        .far_major   (far_best),
        .weight      (weight_best)
    );

    dfrc_decide #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_decide (
        .flags_item     (flags_item),
        .flags_best     (flags_best),
        .near_item      (near_item),
        .far_item       (far_item),
        .near_best      (near_best),
        .far_best       (far_best),
        .weight_item    (weight_item),
        .weight_best    (weight_best),
        .horiz          (horiz),
        .item_is_better (better_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_advance)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_advance && s1_valid_reg)
            better_reg <= better_next;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.item_is_better = better_reg;

endmodule

`default_nettype wire

### rtl/core/dfrc_checker.sv
// ----------------------------------------------------------------------------
// dfrc_checker
// Port-level checks on the comparator's request and result channels.
// ----------------------------------------------------------------------------
`default_nettype none

`include "directional_focus_rect_compare_top_macros.svh"

module dfrc_checker (
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input logic rsp_better
);

    logic       req_acc;
    logic       rsp_acc;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    assign req_acc = req_valid && req_ready;
    assign rsp_acc = rsp_valid && rsp_ready;

    // Items accepted but not yet delivered
    always_comb
    begin
        cnt_next = cnt_reg;
        if (req_acc && !rsp_acc)
            cnt_next = cnt_reg + 2'd1;
        else if (!req_acc && rsp_acc)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    `DFRC_ASSERT_NEXT(a_rsp_valid_hold, rsp_valid && !rsp_ready, rsp_valid, "rsp valid dropped while stalled")
    `DFRC_ASSERT_NEXT(a_rsp_data_hold, rsp_valid && !rsp_ready, $stable(rsp_better), "rsp item changed while stalled")
    `DFRC_ASSERT_NOW(a_req_ready_stall, !req_ready, rsp_valid && !rsp_ready, "req stalled without rsp backpressure")
    `DFRC_ASSERT_NOW(a_rsp_has_source, rsp_valid, cnt_reg != 2'd0 && cnt_reg != 2'd3, "rsp item without pending request")

endmodule

bind directional_focus_rect_compare_top dfrc_checker u_dfrc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_better (rsp.item_is_better)
);

`default_nettype wire
